FILE: rtl/core/bmapnf_pkg.sv
package bmapnf_pkg;

   localparam int MAX_BITS   = 4096;
   localparam int WORD_BITS  = 64;
   localparam int WORD_SHIFT = $clog2(WORD_BITS);
   localparam int MAP_DEPTH  = MAX_BITS / WORD_BITS;
   localparam int ADDR_W     = $clog2(MAP_DEPTH);
   localparam int WORDS_W    = ADDR_W + 1;
   localparam int INDEX_W    = 12;
   localparam int COUNT_W    = 13;
   localparam int KIND_W     = 3;

   localparam logic [COUNT_W-1:0] BIT_COUNT_RESET = COUNT_W'(MAX_BITS);

   localparam logic [KIND_W-1:0] KIND_QUERY     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_MARK_USED = 3'd1;
   localparam logic [KIND_W-1:0] KIND_MARK_FREE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ALL_USED  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ALL_FREE  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_FIND      = 3'd5;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [INDEX_W-1:0] bit_index;
   } req_type;

   typedef struct packed {
      logic               bit_used;
      logic               found;
      logic [INDEX_W-1:0] found_index;
      logic               out_of_range;
   } rsp_type;

   typedef struct packed {
      logic                  any_zero;
      logic [WORD_SHIFT-1:0] index;
   } zfind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIT,
      ST_FILL,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/core/bitmap_allocator_next_fit.sv
// Next-fit bitmap allocator over a 4096-bit map held in a 64 x 64-bit RAM.
// Request channel (req_valid/req_stall/req_data): one beat per request, taken
// only while the sequencer is idle; req_stall stays high for the whole request.
// Response channel (rsp_valid/rsp_stall/rsp_data): exactly one beat per request,
// held in an output register until rsp_stall is low. A new request is taken
// while that beat waits; its own result waits in the sequencer.
// Steps, accept to response valid:
//   query, mark used, mark free: word read, then modify/compare
//   out of range, unknown kind: straight to the finish state
//   mark all used/free: one RAM write per word in use
//   find free: words scanned from the hint, wrapping; the RAM read port and
//   the lowest-zero encoder handle one word per cycle.
// The next request is taken the cycle after the result enters the output
// register.
// csr_data writes the bit count; csr_ready is always high and a write takes
// effect at the next request. Write it only while no request is in flight.
// Reset (synchronous, high) clears the per-word valid bits so every bit reads
// free, sets the hint to zero and the bit count to 4096; no clearing pass runs.
module bitmap_allocator_next_fit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  bmapnf_pkg::req_type            req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output bmapnf_pkg::rsp_type            rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bmapnf_pkg::COUNT_W-1:0] csr_data
);

   bmapnf_pkg::state_type state_ff, state_in;

   logic [bmapnf_pkg::KIND_W-1:0]    kind_ff, kind_in;
   logic [bmapnf_pkg::INDEX_W-1:0]   bit_ff, bit_in;
   logic [bmapnf_pkg::ADDR_W-1:0]    addr_ff, addr_in;
   logic [bmapnf_pkg::WORDS_W-1:0]   rem_ff, rem_in;
   bmapnf_pkg::rsp_type              res_ff, res_in;
   logic [bmapnf_pkg::COUNT_W-1:0]   hint_ff, hint_in;
   logic [bmapnf_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [bmapnf_pkg::MAP_DEPTH-1:0] valid_ff, valid_in;
   logic                             vld_rd_ff, vld_rd_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   bmapnf_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   logic                              ram_rd_en;
   logic [bmapnf_pkg::ADDR_W-1:0]     ram_rd_addr;
   logic                              ram_wr_en;
   logic [bmapnf_pkg::ADDR_W-1:0]     ram_wr_addr;
   logic [bmapnf_pkg::WORD_BITS-1:0]  ram_wr_data;
   logic [bmapnf_pkg::WORD_BITS-1:0]  ram_rd_data;

   logic [bmapnf_pkg::COUNT_W-1:0]    eff_bits;
   logic [bmapnf_pkg::COUNT_W-1:0]    eff_round;
   logic [bmapnf_pkg::WORDS_W-1:0]    words_used;
   logic [bmapnf_pkg::WORDS_W-1:0]    hint_word;
   logic [bmapnf_pkg::ADDR_W-1:0]     first_word;
   logic [bmapnf_pkg::WORDS_W-1:0]    next_full;
   logic [bmapnf_pkg::ADDR_W-1:0]     next_word;
   logic                              last_fill;
   logic [bmapnf_pkg::WORD_BITS-1:0]  cur_word;
   logic [bmapnf_pkg::WORD_BITS-1:0]  bit_mask;
   logic [bmapnf_pkg::INDEX_W-1:0]    cand;
   logic                              hit;
   logic                              in_range;
   logic                              req_accept;
   logic                              rsp_free;
   logic                              rsp_push;
   bmapnf_pkg::zfind_type             zf;

   bmapnf_ram #(
      .WIDTH (bmapnf_pkg::WORD_BITS),
      .DEPTH (bmapnf_pkg::MAP_DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bmapnf_zfind u_zfind (
      .word   (cur_word),
      .result (zf)
   );

   // Bit count clamped to the map size, and words in use rounded up.
   assign eff_bits   = (count_ff > bmapnf_pkg::BIT_COUNT_RESET) ?
                       bmapnf_pkg::BIT_COUNT_RESET : count_ff;
   assign eff_round  = eff_bits + bmapnf_pkg::COUNT_W'(bmapnf_pkg::WORD_BITS - 1);
   assign words_used = eff_round[bmapnf_pkg::COUNT_W-1:bmapnf_pkg::WORD_SHIFT];

   // A hint past the words in use starts the scan at word zero.
   assign hint_word  = hint_ff[bmapnf_pkg::COUNT_W-1:bmapnf_pkg::WORD_SHIFT];
   assign first_word = (hint_word < words_used) ?
                       hint_word[bmapnf_pkg::ADDR_W-1:0] : '0;

   assign next_full  = {1'b0, addr_ff} + bmapnf_pkg::WORDS_W'(1);
   assign next_word  = (next_full == words_used) ? '0 : next_full[bmapnf_pkg::ADDR_W-1:0];
   assign last_fill  = (next_full == words_used);

   // A word never written since reset reads as all free.
   assign cur_word = vld_rd_ff ? ram_rd_data : '0;
   assign bit_mask = bmapnf_pkg::WORD_BITS'(1) << bit_ff[bmapnf_pkg::WORD_SHIFT-1:0];
   assign cand     = {addr_ff, zf.index};
   assign hit      = zf.any_zero && ({1'b0, cand} < eff_bits);
   assign in_range = ({1'b0, req_data.bit_index} < eff_bits);

   assign req_stall  = (state_ff != bmapnf_pkg::ST_IDLE);
   assign req_accept = req_valid && (state_ff == bmapnf_pkg::ST_IDLE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_push   = (state_ff == bmapnf_pkg::ST_DONE) && rsp_free;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bmapnf_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (req_data.kind)
                  bmapnf_pkg::KIND_QUERY, bmapnf_pkg::KIND_MARK_USED,
                  bmapnf_pkg::KIND_MARK_FREE: begin
                     state_in = in_range ? bmapnf_pkg::ST_BIT : bmapnf_pkg::ST_DONE;
                  end
                  bmapnf_pkg::KIND_ALL_USED, bmapnf_pkg::KIND_ALL_FREE: begin
                     state_in = (words_used != '0) ? bmapnf_pkg::ST_FILL :
                                bmapnf_pkg::ST_DONE;
                  end
                  bmapnf_pkg::KIND_FIND: begin
                     state_in = (words_used != '0) ? bmapnf_pkg::ST_SCAN :
                                bmapnf_pkg::ST_DONE;
                  end
                  default: begin
                     state_in = bmapnf_pkg::ST_DONE;
                  end
               endcase
            end
         end
         bmapnf_pkg::ST_BIT: begin
            state_in = bmapnf_pkg::ST_DONE;
         end
         bmapnf_pkg::ST_FILL: begin
            if (last_fill) begin
               state_in = bmapnf_pkg::ST_DONE;
            end
         end
         bmapnf_pkg::ST_SCAN: begin
            if (hit || rem_ff == bmapnf_pkg::WORDS_W'(1)) begin
               state_in = bmapnf_pkg::ST_DONE;
            end
         end
         bmapnf_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = bmapnf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bmapnf_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and RAM controls
   always_comb begin
      kind_in     = kind_ff;
      bit_in      = bit_ff;
      addr_in     = addr_ff;
      rem_in      = rem_ff;
      res_in      = res_ff;
      hint_in     = hint_ff;
      valid_in    = valid_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = '0;
      ram_wr_data = '0;
      unique case (state_ff)
         bmapnf_pkg::ST_IDLE: begin
            if (req_accept) begin
               kind_in = req_data.kind;
               bit_in  = req_data.bit_index;
               res_in  = '0;
               addr_in = '0;
               unique case (req_data.kind)
                  bmapnf_pkg::KIND_QUERY, bmapnf_pkg::KIND_MARK_USED,
                  bmapnf_pkg::KIND_MARK_FREE: begin
                     if (in_range) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = req_data.bit_index[bmapnf_pkg::INDEX_W-1:
                                                         bmapnf_pkg::WORD_SHIFT];
                     end else begin
                        res_in.out_of_range = 1'b1;
                     end
                  end
                  bmapnf_pkg::KIND_FIND: begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = first_word;
                     addr_in     = first_word;
                     rem_in      = words_used;
                  end
                  default: begin
                  end
               endcase
            end
         end
         bmapnf_pkg::ST_BIT: begin
            if (kind_ff == bmapnf_pkg::KIND_QUERY) begin
               res_in.bit_used = cur_word[bit_ff[bmapnf_pkg::WORD_SHIFT-1:0]];
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = bit_ff[bmapnf_pkg::INDEX_W-1:bmapnf_pkg::WORD_SHIFT];
               ram_wr_data = (kind_ff == bmapnf_pkg::KIND_MARK_USED) ?
                             (cur_word | bit_mask) : (cur_word & ~bit_mask);
               valid_in[ram_wr_addr] = 1'b1;
            end
         end
         bmapnf_pkg::ST_FILL: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = addr_ff;
            ram_wr_data = (kind_ff == bmapnf_pkg::KIND_ALL_USED) ? '1 : '0;
            valid_in[addr_ff] = 1'b1;
            addr_in     = next_full[bmapnf_pkg::ADDR_W-1:0];
         end
         bmapnf_pkg::ST_SCAN: begin
            if (hit) begin
               res_in.found       = 1'b1;
               res_in.found_index = cand;
               hint_in            = {1'b0, cand} + bmapnf_pkg::COUNT_W'(1);
            end else if (rem_ff != bmapnf_pkg::WORDS_W'(1)) begin
               // Advance the read one word ahead, wrapping at the words in use.
               ram_rd_en   = 1'b1;
               ram_rd_addr = next_word;
               addr_in     = next_word;
               rem_in      = rem_ff - bmapnf_pkg::WORDS_W'(1);
            end
         end
         bmapnf_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
      vld_rd_in    = ram_rd_en ? valid_ff[ram_rd_addr] : vld_rd_ff;
      rsp_valid_in = rsp_push || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = rsp_push ? res_ff : rsp_data_ff;
      count_in     = csr_valid ? csr_data : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmapnf_pkg::ST_IDLE;
         valid_ff     <= '0;
         vld_rd_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hint_ff      <= '0;
         count_ff     <= bmapnf_pkg::BIT_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         vld_rd_ff    <= vld_rd_in;
         rsp_valid_ff <= rsp_valid_in;
         hint_ff      <= hint_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      bit_ff      <= bit_in;
      addr_ff     <= addr_in;
      rem_ff      <= rem_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bmapnf_pkg::ST_SCAN) |-> !ram_wr_en)
      else $error("map written during scan");

   a_scan_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bmapnf_pkg::ST_SCAN) |-> (rem_ff != '0))
      else $error("scan running with no words left");

   a_scan_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bmapnf_pkg::ST_SCAN) |-> ({1'b0, addr_ff} < words_used))
      else $error("scan address beyond words in use");

   a_push_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == bmapnf_pkg::ST_DONE))
      else $error("response loaded outside finish state");

   a_found_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.found && rsp_data_ff.out_of_range))
      else $error("found and out of range both set");
`endif

endmodule

FILE: rtl/core/bmapnf_ram.sv
module bmapnf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/bmapnf_zfind.sv
module bmapnf_zfind (
   input  logic [bmapnf_pkg::WORD_BITS-1:0] word,
   output bmapnf_pkg::zfind_type            result
);

   logic [bmapnf_pkg::WORD_BITS-1:0]  inv;
   logic [bmapnf_pkg::WORD_BITS-1:0]  lowest;
   logic [bmapnf_pkg::WORD_SHIFT-1:0] index;

   // Isolate the lowest clear bit, then encode the one-hot position.
   assign inv    = ~word;
   assign lowest = inv & (word + bmapnf_pkg::WORD_BITS'(1));

   always_comb begin
      index = '0;
      for (int b = 0; b < bmapnf_pkg::WORD_BITS; b++) begin
         index = index | (lowest[b] ? bmapnf_pkg::WORD_SHIFT'(b) : '0);
      end
   end

   assign result.any_zero = |inv;
   assign result.index    = index;

endmodule

FILE: tb/bitmap_alloc_checker.sv
`timescale 1ns / 100ps

module bitmap_alloc_checker
   import bmapnf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  req_type            req_data,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  rsp_type            rsp_data,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_data,
   output int                 fail_count,
   output int                 pending
);

   logic [WORD_BITS-1:0] alloc_words [MAP_DEPTH];
   logic [COUNT_W-1:0]   hint_q;
   logic [COUNT_W-1:0]   count_q;
   rsp_type              awaited_rsps [$];
   int                   mism_count;

   initial begin
      mism_count = 0;
   end

   function automatic int first_clear(input logic [WORD_BITS-1:0] w);
      for (int n = 0; n < WORD_BITS; n++)
         if (!w[n]) return n;
      return WORD_BITS - 1;
   endfunction

   // Scan words [from, upto) for the lowest free bit below lim.
   function automatic bit scan_words(input int from, input int upto, input int lim,
                                     output int idx);
      int cand;
      idx = 0;
      for (int w = from; w < upto && w < MAP_DEPTH; w++) begin
         if (&alloc_words[w]) continue;
         cand = w * WORD_BITS + first_clear(alloc_words[w]);
         if (cand < lim) begin
            idx = cand;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic rsp_type next_fit_result(input req_type item);
      rsp_type r;
      int      lim, nwords, start, wrap_end, hit, wi, bi;
      bit      got_hit;
      r = '0;
      lim = (int'(count_q) > MAX_BITS) ? MAX_BITS : int'(count_q);
      nwords = (lim + WORD_BITS - 1) / WORD_BITS;
      case (item.kind)
         KIND_QUERY, KIND_MARK_USED, KIND_MARK_FREE: begin
            if (int'(item.bit_index) >= lim) begin
               r.out_of_range = 1'b1;
            end else begin
               wi = int'(item.bit_index) / WORD_BITS;
               bi = int'(item.bit_index) % WORD_BITS;
               if (item.kind == KIND_QUERY)
                  r.bit_used = alloc_words[wi][bi];
               else if (item.kind == KIND_MARK_USED)
                  alloc_words[wi][bi] = 1'b1;
               else
                  alloc_words[wi][bi] = 1'b0;
            end
         end
         KIND_ALL_USED, KIND_ALL_FREE: begin
            for (int w = 0; w < nwords && w < MAP_DEPTH; w++)
               alloc_words[w] = (item.kind == KIND_ALL_USED) ? '1 : '0;
         end
         KIND_FIND: begin
            start = int'(hint_q) / WORD_BITS;
            wrap_end = (start < nwords) ? start : nwords;
            got_hit = scan_words(start, nwords, lim, hit);
            // wrap around to the words ahead of the hint
            if (!got_hit) got_hit = scan_words(0, wrap_end, lim, hit);
            if (got_hit) begin
               r.found       = 1'b1;
               r.found_index = hit[INDEX_W-1:0];
               hint_q        = COUNT_W'(hit + 1);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type got, want;
      if (reset) begin
         for (int i = 0; i < MAP_DEPTH; i++) alloc_words[i] = '0;
         hint_q  = '0;
         count_q = BIT_COUNT_RESET;
         awaited_rsps.delete();
      end else begin
         if (csr_valid && csr_ready) count_q = csr_data;
         if (req_valid && !req_stall) awaited_rsps.push_back(next_fit_result(req_data));
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (awaited_rsps.size() == 0) begin
               mism_count++;
               if (mism_count <= 10)
                  $display("unexpected response beat: used=%0d found=%0d index=%0d oor=%0d",
                           got.bit_used, got.found, got.found_index, got.out_of_range);
            end else begin
               want = awaited_rsps.pop_front();
               if (got.bit_used !== want.bit_used || got.found !== want.found ||
                   got.found_index !== want.found_index ||
                   got.out_of_range !== want.out_of_range) begin
                  mism_count++;
                  if (mism_count <= 10)
                     $display({"response mismatch: expected used=%0d found=%0d index=%0d ",
                               "oor=%0d, got used=%0d found=%0d index=%0d oor=%0d"},
                              want.bit_used, want.found, want.found_index,
                              want.out_of_range, got.bit_used, got.found,
                              got.found_index, got.out_of_range);
               end
            end
         end
      end
      fail_count <= mism_count;
      pending    <= awaited_rsps.size();
   end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import bmapnf_pkg::*;

   localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int PHASE_ITEMS  = 100;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_type            req_data  = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_type            rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_data  = '0;

   int fail_count;
   int pending;
   int idle_pct   = 10;
   int items_sent = 0;
   int lim_bits   = MAX_BITS;

   always #4 clock = ~clock;

   bitmap_allocator_next_fit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   bitmap_alloc_checker alloc_chk (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < idle_pct);
   end

   // Mostly in range; now and then a bit past the count.
   function automatic logic [INDEX_W-1:0] random_bit_index();
      if (lim_bits == 0 || ($urandom_range(0, 19) == 0 && lim_bits < MAX_BITS))
         return INDEX_W'($urandom_range(lim_bits, MAX_BITS - 1));
      return INDEX_W'($urandom_range(0, lim_bits - 1));
   endfunction

   task automatic send_req(input logic [KIND_W-1:0] k, input logic [INDEX_W-1:0] idx);
      req_type item;
      item.kind      = k;
      item.bit_index = idx;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_count(input logic [COUNT_W-1:0] value);
      drain_all();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      lim_bits = (int'(value) > MAX_BITS) ? MAX_BITS : int'(value);
      @(posedge clock);
   endtask

   task automatic send_mix();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         send_req(KIND_FIND, INDEX_W'($urandom_range(0, 4095)));
      else if (pick < 85)
         send_req(KIND_QUERY, random_bit_index());
      else
         send_req(KIND_MARK_USED, random_bit_index());
   endtask

   task automatic run_phase(input int n_items);
      int stop_at;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         case ($urandom_range(0, 9))
            0: begin
               repeat ($urandom_range(1, 4))
                  send_req(KIND_W'($urandom_range(0, 7)), INDEX_W'($urandom_range(0, 4095)));
            end
            1, 2, 3, 4: begin
               // fill the map, punch a few holes, then hunt for them
               send_req(KIND_ALL_USED, INDEX_W'($urandom_range(0, 4095)));
               repeat ($urandom_range(1, 6)) send_req(KIND_MARK_FREE, random_bit_index());
               repeat ($urandom_range(2, 8)) send_mix();
            end
            5, 6, 7: begin
               if ($urandom_range(0, 3) != 0)
                  send_req(KIND_ALL_FREE, INDEX_W'($urandom_range(0, 4095)));
               repeat ($urandom_range(1, 10)) send_req(KIND_MARK_USED, random_bit_index());
               repeat ($urandom_range(2, 8)) send_mix();
            end
            default: begin
               repeat ($urandom_range(1, 4))
                  send_req(KIND_W'($urandom_range(0, 5)), random_bit_index());
            end
         endcase
      end
   endtask

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("bitmap_allocator_next_fit test failed");
      $finish;
   end

   initial begin
      logic [COUNT_W-1:0] phase_count [10];
      phase_count = '{13'd8191, 13'd1, 13'd64, 13'd65, 13'd0,
                      13'd4095, 13'd4097, 13'd100, 13'd0, 13'd4096};
      phase_count[4] = COUNT_W'($urandom_range(2, 4095));
      phase_count[8] = COUNT_W'($urandom_range(0, 8191));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_count(COUNT_W'(MAX_BITS));
      send_req(KIND_QUERY, 12'd0);
      send_req(KIND_FIND, 12'd0);
      send_req(KIND_MARK_USED, 12'd0);
      send_req(KIND_MARK_USED, 12'hFFF);
      send_req(KIND_QUERY, 12'd0);
      send_req(KIND_QUERY, 12'hFFF);
      send_req(KIND_FIND, 12'hFFF);
      send_req(KIND_MARK_FREE, 12'd0);
      send_req(KIND_SPARE_A, 12'hFFF);
      send_req(KIND_SPARE_B, 12'd0);
      send_req(KIND_ALL_USED, 12'd0);
      send_req(KIND_FIND, 12'd0);
      send_req(KIND_MARK_FREE, 12'hFFF);
      // last bit found: the hint moves past the last word, so the next find wraps
      send_req(KIND_FIND, 12'd0);
      send_req(KIND_FIND, 12'd0);
      send_req(KIND_MARK_FREE, 12'd63);
      send_req(KIND_FIND, 12'd0);
      send_req(KIND_QUERY, 12'hAAA);
      send_req(KIND_ALL_FREE, 12'h555);

      // empty map: every single-bit request flagged, nothing found
      write_count(13'd0);
      send_req(KIND_QUERY, 12'd0);
      send_req(KIND_MARK_USED, 12'hFFF);
      send_req(KIND_ALL_USED, 12'd0);
      send_req(KIND_FIND, 12'd0);
      send_req(KIND_MARK_FREE, 12'd0);

      for (int p = 0; p < 10; p++) begin
         write_count(phase_count[p]);
         idle_pct = (p == 0) ? 0 : 10;
         if (p == 5) begin
            run_phase(PHASE_ITEMS / 2);
            drain_all();
            run_phase(PHASE_ITEMS - PHASE_ITEMS / 2);
         end else begin
            run_phase(PHASE_ITEMS);
         end
      end

      drain_all();
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("bitmap_allocator_next_fit test passed");
      else
         $display("bitmap_allocator_next_fit test failed");
      $finish;
   end

endmodule
